### src/ccsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Coil combine package
// Shared types and fixed constants for the coil combination block.
// ----------------------------------------------------------------------------
package ccsr_pkg;

    // Output field width and the packed output word
    localparam int OUT_W       = 22;
    localparam int OUT_TDATA_W = ((2 * OUT_W + 7) / 8) * 8;
    localparam int OUT_MAX     = 2097151;
    localparam int OUT_MIN     = -2097152;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam int GS_W       = 7;

    localparam logic [CFG_IDX_W-1:0] REG_METHOD     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_SIZE = 1'b1;

    localparam logic METHOD_ADD = 1'b0;
    localparam logic METHOD_RMS = 1'b1;

    // Sequencer of the top level
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_RE,
        ST_SQ_IM,
        ST_ACC,
        ST_DIV_GO,
        ST_ROOT,
        ST_EMIT
    } t_state;

    // Phases of the divide / root engine
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DIV,
        PH_SQRT
    } t_eng_phase;

    // Status from the engine to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_eng_status;

endpackage : ccsr_pkg
`default_nettype wire

### src/ccsr_squarer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Registered squarer
// Squares one signed sample through its magnitude; product registered.
// ----------------------------------------------------------------------------
module ccsr_squarer #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic signed [SAMPLE_BITS-1:0]   i_sample,
    output logic             [2*SAMPLE_BITS-1:0] o_square
);
    import ccsr_pkg::*;

    logic [SAMPLE_BITS-1:0]   w_mag;
    logic [2*SAMPLE_BITS-1:0] r_square;

    // most negative value maps to 2^(n-1), which still fits unsigned
    assign w_mag = i_sample[SAMPLE_BITS-1] ? (~i_sample + 1'b1) : i_sample;

    always_ff @(posedge i_clk) begin
        r_square <= (2*SAMPLE_BITS)'(w_mag) * (2*SAMPLE_BITS)'(w_mag);
    end

    assign o_square = r_square;

endmodule : ccsr_squarer
`default_nettype wire

### src/ccsr_divsqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Divide and root engine
// Restoring divide of the power sum by the count, then digit-by-digit
// integer square root of the quotient, both on one shared trial subtractor.
// ----------------------------------------------------------------------------
module ccsr_divsqrt #(
    parameter int POW_W = 38,
    parameter int CNT_W = 7
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [POW_W-1:0]           i_dividend,
    input  wire logic [CNT_W-1:0]           i_divisor,
    output ccsr_pkg::t_eng_status           o_status,
    output logic      [(POW_W+1)/2-1:0]     o_root
);
    import ccsr_pkg::*;

    localparam int ROOT_W = (POW_W + 1) / 2;
    localparam int WORK_W = 2 * ROOT_W;
    localparam int SUB_W  = (CNT_W + 1 > ROOT_W + 2) ? CNT_W + 1 : ROOT_W + 2;
    localparam int STEP_W = $clog2(WORK_W);

    t_eng_phase          r_phase, n_phase;
    logic [WORK_W-1:0]   r_work, n_work;
    logic [SUB_W-1:0]    r_rem, n_rem;
    logic [ROOT_W-1:0]   r_root, n_root;
    logic [CNT_W-1:0]    r_divisor, n_divisor;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_done, n_done;

    logic [CNT_W:0]      w_div_a;
    logic [ROOT_W+1:0]   w_sq_a;
    logic [ROOT_W+1:0]   w_sq_b;
    logic [SUB_W-1:0]    w_op_a;
    logic [SUB_W-1:0]    w_op_b;
    logic [SUB_W:0]      w_diff;
    logic                w_ge;
    logic [SUB_W-1:0]    w_rem_next;

    // shared trial subtractor
    assign w_div_a    = {r_rem[CNT_W-1:0], r_work[WORK_W-1]};
    assign w_sq_a     = {r_rem[ROOT_W-1:0], r_work[WORK_W-1 -: 2]};
    assign w_sq_b     = {r_root, 2'b01};
    assign w_op_a     = (r_phase == PH_SQRT) ? SUB_W'(w_sq_a) : SUB_W'(w_div_a);
    assign w_op_b     = (r_phase == PH_SQRT) ? SUB_W'(w_sq_b) : SUB_W'(r_divisor);
    assign w_diff     = {1'b0, w_op_a} - {1'b0, w_op_b};
    assign w_ge       = ~w_diff[SUB_W];
    assign w_rem_next = w_ge ? w_diff[SUB_W-1:0] : w_op_a;

    // next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_IDLE: begin
                if (i_start) begin
                    n_phase = PH_DIV;
                end
            end
            PH_DIV: begin
                if (r_step == '0) begin
                    n_phase = PH_SQRT;
                end
            end
            PH_SQRT: begin
                if (r_step == '0) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // datapath per phase
    always_comb begin
        n_work    = r_work;
        n_rem     = r_rem;
        n_root    = r_root;
        n_divisor = r_divisor;
        n_step    = r_step;
        n_done    = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                if (i_start) begin
                    n_work    = WORK_W'(i_dividend);
                    n_rem     = '0;
                    n_root    = '0;
                    n_divisor = i_divisor;
                    n_step    = STEP_W'(WORK_W - 1);
                end
            end
            PH_DIV: begin
                // quotient bits enter from the bottom as dividend bits leave
                n_work = {r_work[WORK_W-2:0], w_ge};
                if (r_step == '0) begin
                    n_rem  = '0;
                    n_step = STEP_W'(ROOT_W - 1);
                end else begin
                    n_rem  = w_rem_next;
                    n_step = r_step - 1'b1;
                end
            end
            PH_SQRT: begin
                n_work = {r_work[WORK_W-3:0], 2'b00};
                n_rem  = w_rem_next;
                n_root = {r_root[ROOT_W-2:0], w_ge};
                if (r_step == '0) begin
                    n_done = 1'b1;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work    <= n_work;
        r_rem     <= n_rem;
        r_root    <= n_root;
        r_divisor <= n_divisor;
        r_step    <= n_step;
    end

    assign o_status.busy = (r_phase != PH_IDLE);
    assign o_status.done = r_done;
    assign o_root        = r_root;

endmodule : ccsr_divsqrt
`default_nettype wire

### src/coil_combine_sum_or_rms_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Coil combine, complex sum or root of mean sum of squares
// Accumulates complex samples per group and emits the complex sum or the
// integer root of the mean power when a group closes.
// ----------------------------------------------------------------------------
// Input pacing: the shared squarer handles one sample at a time (real
//   part, then imaginary part, then the power add), and no new sample is
//   taken before it is done. A sample that closes a group holds the input
//   until its result word is loaded, longer while an earlier one still waits.
// Result path: in complex sum mode the closing sample passes the square,
//   accumulate and emit states, and emit loads the output register. Root
//   mode adds the divide/root engine, a divide phase then a root phase;
//   no sample is taken meanwhile.
// Reset: synchronous, active low; clears the sequencer, the accumulators,
//   the count and the output valid, and sets method to sum, group size to 1.
// ----------------------------------------------------------------------------
module coil_combine_sum_or_rms_top #(
    parameter int MAX_GROUP   = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    // configuration writes
    input  wire logic                                      i_cfg_wr_en,
    input  wire logic [ccsr_pkg::CFG_IDX_W-1:0]            i_cfg_index,
    input  wire logic [ccsr_pkg::CFG_DATA_W-1:0]           i_cfg_data,
    // sample words in
    input  wire logic                                      s_axis_tvalid,
    output logic                                           s_axis_tready,
    // fields from bit 0: sample_re, sample_im, zero fill
    input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]        s_axis_tdata,
    // result words out
    output logic                                           m_axis_tvalid,
    input  wire logic                                      m_axis_tready,
    // fields from bit 0: out_re, out_im, zero fill
    output logic [ccsr_pkg::OUT_TDATA_W-1:0]               m_axis_tdata
);
    import ccsr_pkg::*;

    localparam int CNT_W  = $clog2(MAX_GROUP + 1);
    localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_GROUP);
    localparam int POW_W  = 2 * SAMPLE_BITS + $clog2(MAX_GROUP);
    localparam int ROOT_W = (POW_W + 1) / 2;
    localparam int LIM_W  = (CNT_W > GS_W) ? CNT_W : GS_W;
    localparam int CMP_W  = (SUM_W > OUT_W) ? SUM_W : OUT_W;
    localparam int RCMP_W = (ROOT_W > OUT_W) ? ROOT_W : OUT_W;

    localparam logic signed [CMP_W-1:0] SAT_HI   = CMP_W'(OUT_MAX);
    localparam logic signed [CMP_W-1:0] SAT_LO   = CMP_W'(OUT_MIN);
    localparam logic        [RCMP_W-1:0] ROOT_HI = RCMP_W'(OUT_MAX);

    // configuration registers
    logic                    r_method;
    logic [GS_W-1:0]         r_group_size;

    // sequencer
    t_state                  r_state, n_state;
    logic                    w_accept;
    logic                    w_sel_im;
    logic                    w_pow_add;
    logic                    w_seen_inc;
    logic                    w_eng_start;
    logic                    w_out_load;
    logic                    w_close;

    // group accumulators and the sample held for squaring
    logic signed [SAMPLE_BITS-1:0] r_re;
    logic signed [SAMPLE_BITS-1:0] r_im;
    logic signed [SAMPLE_BITS-1:0] w_in_re;
    logic signed [SAMPLE_BITS-1:0] w_in_im;
    logic signed [SAMPLE_BITS-1:0] w_mul_in;
    logic [2*SAMPLE_BITS-1:0]      w_square;
    logic signed [SUM_W-1:0]       r_sum_re;
    logic signed [SUM_W-1:0]       r_sum_im;
    logic [POW_W-1:0]              r_power;
    logic [CNT_W-1:0]              r_seen;
    logic [CNT_W-1:0]              w_seen_next;
    logic [LIM_W-1:0]              w_gs;
    logic [LIM_W-1:0]              w_limit;

    // engine
    t_eng_status                   w_eng;
    logic [ROOT_W-1:0]             w_root;

    // output stage
    logic                          r_out_valid;
    logic [OUT_W-1:0]              r_out_re;
    logic [OUT_W-1:0]              r_out_im;
    logic signed [CMP_W-1:0]       w_re_ext;
    logic signed [CMP_W-1:0]       w_im_ext;
    logic [OUT_W-1:0]              w_re_sat;
    logic [OUT_W-1:0]              w_im_sat;
    logic [RCMP_W-1:0]             w_root_ext;
    logic [OUT_W-1:0]              w_mag;

    // ------------------------------------------------------------------
    // configuration: unchecked by the block, the user writes only while no group result is outstanding
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_method     <= METHOD_ADD;
            r_group_size <= GS_W'(1);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_METHOD:     r_method     <= i_cfg_data[0];
                REG_GROUP_SIZE: r_group_size <= i_cfg_data[GS_W-1:0];
                default:        r_method     <= r_method;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // group close test: zero counts as one, oversize clamps to MAX_GROUP
    // ------------------------------------------------------------------
    assign w_gs        = LIM_W'(r_group_size);
    assign w_limit     = (w_gs == '0)                 ? LIM_W'(1) :
                         (w_gs > LIM_W'(MAX_GROUP))   ? LIM_W'(MAX_GROUP) : w_gs;
    assign w_seen_next = r_seen + 1'b1;
    assign w_close     = (LIM_W'(w_seen_next) >= w_limit);

    // ------------------------------------------------------------------
    // sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = ST_SQ_RE;
                end
            end
            ST_SQ_RE: begin
                n_state = ST_SQ_IM;
            end
            ST_SQ_IM: begin
                n_state = ST_ACC;
            end
            ST_ACC: begin
                if (!w_close) begin
                    n_state = ST_IDLE;
                end else if (r_method == METHOD_RMS) begin
                    n_state = ST_DIV_GO;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_DIV_GO: begin
                n_state = ST_ROOT;
            end
            ST_ROOT: begin
                if (w_eng.done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer: controls per state
    // ------------------------------------------------------------------
    always_comb begin
        s_axis_tready = 1'b0;
        w_sel_im      = 1'b0;
        w_pow_add     = 1'b0;
        w_seen_inc    = 1'b0;
        w_eng_start   = 1'b0;
        w_out_load    = 1'b0;
        case (r_state)
            ST_IDLE:   s_axis_tready = 1'b1;
            ST_SQ_RE:  w_sel_im      = 1'b0;
            ST_SQ_IM: begin
                // square of the real part is ready; start the imaginary one
                w_sel_im  = 1'b1;
                w_pow_add = 1'b1;
            end
            ST_ACC: begin
                w_pow_add  = 1'b1;
                w_seen_inc = 1'b1;
            end
            ST_DIV_GO: w_eng_start = 1'b1;
            ST_ROOT:   w_eng_start = 1'b0;
            ST_EMIT:   w_out_load  = !r_out_valid || m_axis_tready;
            default:   s_axis_tready = 1'b0;
        endcase
    end

    assign w_accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // shared squarer: real part first, then imaginary part
    // ------------------------------------------------------------------
    assign w_in_re  = s_axis_tdata[SAMPLE_BITS-1:0];
    assign w_in_im  = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign w_mul_in = w_sel_im ? r_im : r_re;

    ccsr_squarer #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_squarer (
        .i_clk    (i_clk),
        .i_sample (w_mul_in),
        .o_square (w_square)
    );

    // hold the sample for the squarer
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_re <= w_in_re;
            r_im <= w_in_im;
        end
    end

    // ------------------------------------------------------------------
    // accumulators: complex sums on accept, power in two adds (real square,
    // then imaginary square), all cleared when the result word is loaded
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_re <= '0;
            r_sum_im <= '0;
            r_power  <= '0;
            r_seen   <= '0;
        end else if (w_out_load) begin
            r_sum_re <= '0;
            r_sum_im <= '0;
            r_power  <= '0;
            r_seen   <= '0;
        end else begin
            if (w_accept) begin
                r_sum_re <= r_sum_re + SUM_W'(w_in_re);
                r_sum_im <= r_sum_im + SUM_W'(w_in_im);
            end
            if (w_pow_add) begin
                r_power <= r_power + POW_W'(w_square);
            end
            if (w_seen_inc) begin
                r_seen <= w_seen_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // divide by count, then integer square root
    // ------------------------------------------------------------------
    ccsr_divsqrt #(
        .POW_W (POW_W),
        .CNT_W (CNT_W)
    ) u_divsqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_eng_start),
        .i_dividend (r_power),
        .i_divisor  (r_seen),
        .o_status   (w_eng),
        .o_root     (w_root)
    );

    // ------------------------------------------------------------------
    // saturate to the signed output range
    // ------------------------------------------------------------------
    assign w_re_ext = CMP_W'(r_sum_re);
    assign w_im_ext = CMP_W'(r_sum_im);
    assign w_re_sat = (w_re_ext > SAT_HI) ? OUT_W'(SAT_HI) :
                      (w_re_ext < SAT_LO) ? OUT_W'(SAT_LO) : w_re_ext[OUT_W-1:0];
    assign w_im_sat = (w_im_ext > SAT_HI) ? OUT_W'(SAT_HI) :
                      (w_im_ext < SAT_LO) ? OUT_W'(SAT_LO) : w_im_ext[OUT_W-1:0];

    assign w_root_ext = RCMP_W'(w_root);
    assign w_mag      = (w_root_ext > ROOT_HI) ? OUT_W'(ROOT_HI) : w_root_ext[OUT_W-1:0];

    // ------------------------------------------------------------------
    // output register: holds the word while the sink stalls
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            if (r_method == METHOD_RMS) begin
                r_out_re <= w_mag;
                r_out_im <= '0;
            end else begin
                r_out_re <= w_re_sat;
                r_out_im <= w_im_sat;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'({r_out_im, r_out_re});

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_seen_below_max : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_seen < CNT_W'(MAX_GROUP)))
        else $error("open group count reached the group limit while idle");

    a_start_when_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_eng_start |-> !w_eng.busy)
        else $error("engine started while busy");

    a_done_in_root : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_eng.done |-> (r_state == ST_ROOT))
        else $error("engine finished outside the root wait");

    a_load_from_emit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == ST_EMIT))
        else $error("result word appeared without an emit step");

endmodule : coil_combine_sum_or_rms_top
`default_nettype wire
